// ----- rtl/ckd_pkg.sv -----
`timescale 1ns / 1ps

package ckd_pkg;

  localparam logic [1:0] MODE_ADD  = 2'd0;
  localparam logic [1:0] MODE_DEL  = 2'd1;
  localparam logic [1:0] MODE_LIST = 2'd2;
  localparam logic [1:0] MODE_INV  = 2'd3;

  typedef enum logic [2:0] {
    STS_ADDED    = 3'd0,
    STS_FULL     = 3'd1,
    STS_REMOVED  = 3'd2,
    STS_NOTFOUND = 3'd3,
    STS_LISTED   = 3'd4,
    STS_EMPTY    = 3'd5,
    STS_INVALID  = 3'd6
  } status_t;

  // microprogram step addresses
  typedef enum logic [2:0] {
    S_FETCH    = 3'd0,
    S_ADD      = 3'd1,
    S_DEL      = 3'd2,
    S_SHIFT    = 3'd3,
    S_LIST     = 3'd4,
    S_LIST_RUN = 3'd5,
    S_INV      = 3'd6
  } step_t;

  // branch conditions
  typedef enum logic [2:0] {
    C_NEVER     = 3'd0,
    C_FIRE      = 3'd1,
    C_FULL      = 3'd2,
    C_HIT       = 3'd3,
    C_SCAN_END  = 3'd4,
    C_SHIFT_END = 3'd5,
    C_LIST_LAST = 3'd6,
    C_EMPTY     = 3'd7
  } cond_t;

  typedef struct packed {
    logic    load;
    logic    disp;
    logic    rd;
    logic    wr_key;
    logic    wr_shift;
    logic    set_wa;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    emit;
    logic    last;
    logic    key_sel;
    status_t st;
  } act_t;

  // two prioritised branches and a fall-through, each with its own actions
  typedef struct packed {
    cond_t ca;
    step_t ta;
    act_t  aa;
    cond_t cb;
    step_t tb;
    act_t  ab;
    step_t tc;
    act_t  ac;
  } uword_t;

  function automatic uword_t uprog(input step_t s);
    uword_t w;
    w = '0;
    unique case (s)
      S_FETCH: begin
        w.ca      = C_FIRE;
        w.aa.load = 1'b1;
        w.aa.disp = 1'b1;
        w.tc      = S_FETCH;
      end
      S_ADD: begin
        w.ca         = C_FULL;
        w.ta         = S_FETCH;
        w.aa.emit    = 1'b1;
        w.aa.last    = 1'b1;
        w.aa.st      = STS_FULL;
        w.tc         = S_FETCH;
        w.ac.wr_key  = 1'b1;
        w.ac.cnt_inc = 1'b1;
        w.ac.emit    = 1'b1;
        w.ac.last    = 1'b1;
        w.ac.st      = STS_ADDED;
      end
      S_DEL: begin
        w.ca        = C_HIT;
        w.ta        = S_SHIFT;
        w.aa.set_wa = 1'b1;
        w.cb        = C_SCAN_END;
        w.tb        = S_FETCH;
        w.ab.emit   = 1'b1;
        w.ab.last   = 1'b1;
        w.ab.st     = STS_NOTFOUND;
        w.tc        = S_DEL;
        w.ac.rd     = 1'b1;
      end
      S_SHIFT: begin
        w.ca          = C_SHIFT_END;
        w.ta          = S_FETCH;
        w.aa.cnt_dec  = 1'b1;
        w.aa.emit     = 1'b1;
        w.aa.last     = 1'b1;
        w.aa.st       = STS_REMOVED;
        w.tc          = S_SHIFT;
        w.ac.rd       = 1'b1;
        w.ac.wr_shift = 1'b1;
      end
      S_LIST: begin
        w.ca      = C_EMPTY;
        w.ta      = S_FETCH;
        w.aa.emit = 1'b1;
        w.aa.last = 1'b1;
        w.aa.st   = STS_EMPTY;
        w.tc      = S_LIST_RUN;
        w.ac.rd   = 1'b1;
      end
      S_LIST_RUN: begin
        w.ca         = C_LIST_LAST;
        w.ta         = S_FETCH;
        w.aa.emit    = 1'b1;
        w.aa.last    = 1'b1;
        w.aa.key_sel = 1'b1;
        w.aa.st      = STS_LISTED;
        w.tc         = S_LIST_RUN;
        w.ac.rd      = 1'b1;
        w.ac.emit    = 1'b1;
        w.ac.key_sel = 1'b1;
        w.ac.st      = STS_LISTED;
      end
      S_INV: begin
        w.tc      = S_FETCH;
        w.ac.emit = 1'b1;
        w.ac.last = 1'b1;
        w.ac.st   = STS_INVALID;
      end
      default: begin
        w.tc = S_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/compacting_key_directory_core.sv -----
`timescale 1ns / 1ps
// add, full and invalid: the add or invalid step after acceptance registers a single beat
// delete: one entry read per cycle until a hit or the scan end, then one per cycle shifted
// list: the list step reads the first entry, then one beat per entry and per cycle unless the output stalls
// throughput: one item at a time, the next is taken once the sequencer is back at fetch
// reset (rst_n, synchronous, active low): empty directory, capacity 64, output idle

module compacting_key_directory_core #(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // config write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,     // capacity_limit
  // input beats
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // [15:0] key
  input  logic [1:0]  in_tuser,     // [1:0] mode
  // result beats
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,    // [15:0] entry_key
  output logic [2:0]  out_tuser,    // [2:0] status
  output logic        out_tlast
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SB = (KEY_BITS < 16) ? KEY_BITS : 16;

  logic [SB-1:0] mem [DEPTH];

  ckd_pkg::step_t upc_r, upc_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  logic [AW-1:0]  wa_r, wa_nxt;
  logic           rd_ok_r, rd_ok_nxt;
  logic [SB-1:0]  key_r, key_nxt;
  logic [SB-1:0]  rdata_r;
  logic [6:0]     cap_r, cap_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [15:0]    out_data_r, out_data_nxt;
  logic [2:0]     out_user_r, out_user_nxt;
  logic           out_last_r, out_last_nxt;

  ckd_pkg::uword_t uw;
  ckd_pkg::act_t   act;
  ckd_pkg::step_t  tgt;
  ckd_pkg::step_t  disp_tgt;
  logic [7:0]      cond_v;
  logic            fire_in;
  logic            full;
  logic            hit;
  logic            scan_end;
  logic            stall;
  logic            go;
  logic            rd_fire;
  logic            wr_fire;
  logic [AW-1:0]   wr_addr;
  logic [SB-1:0]   wr_data;
  logic [CW-1:0]   idx_m1;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (upc_r == ckd_pkg::S_FETCH);
  assign fire_in    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  assign full     = (7'(count_r) >= cap_r) || (count_r == CW'(DEPTH));
  assign hit      = rd_ok_r && (rdata_r == key_r);
  assign scan_end = (idx_r == count_r);
  assign idx_m1   = idx_r - CW'(1);

  always_comb begin
    cond_v                         = '0;
    cond_v[ckd_pkg::C_NEVER]       = 1'b0;
    cond_v[ckd_pkg::C_FIRE]        = fire_in;
    cond_v[ckd_pkg::C_FULL]        = full;
    cond_v[ckd_pkg::C_HIT]         = hit;
    cond_v[ckd_pkg::C_SCAN_END]    = scan_end;
    cond_v[ckd_pkg::C_SHIFT_END]   = scan_end && !rd_ok_r;
    cond_v[ckd_pkg::C_LIST_LAST]   = rd_ok_r && scan_end;
    cond_v[ckd_pkg::C_EMPTY]       = (count_r == '0);
  end

  always_comb begin
    unique case (in_tuser)
      ckd_pkg::MODE_ADD:  disp_tgt = ckd_pkg::S_ADD;
      ckd_pkg::MODE_DEL:  disp_tgt = ckd_pkg::S_DEL;
      ckd_pkg::MODE_LIST: disp_tgt = ckd_pkg::S_LIST;
      ckd_pkg::MODE_INV:  disp_tgt = ckd_pkg::S_INV;
    endcase
  end

  // pick the branch of the current control word
  always_comb begin
    uw = ckd_pkg::uprog(upc_r);
    priority if (cond_v[uw.ca]) begin
      act = uw.aa;
      tgt = uw.ta;
    end else if (cond_v[uw.cb]) begin
      act = uw.ab;
      tgt = uw.tb;
    end else begin
      act = uw.ac;
      tgt = uw.tc;
    end
  end

  // a step that emits waits while the output register still holds an untaken beat
  assign stall   = act.emit && out_valid_r && !out_tready;
  assign go      = !stall;
  assign rd_fire = go && act.rd && (idx_r < count_r);
  assign wr_fire = go && (act.wr_key || (act.wr_shift && rd_ok_r));
  assign wr_addr = act.wr_key ? count_r[AW-1:0] : wa_r;
  assign wr_data = act.wr_key ? key_r : rdata_r;

  always_comb begin
    upc_nxt       = upc_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    wa_nxt        = wa_r;
    rd_ok_nxt     = rd_ok_r;
    key_nxt       = key_r;
    cap_nxt       = cap_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;

    if (cfg_valid && cfg_ready) begin
      cap_nxt = cfg_data;
    end

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (go) begin
      upc_nxt   = act.disp ? disp_tgt : tgt;
      rd_ok_nxt = rd_fire;
      if (act.load) begin
        key_nxt = in_tdata[SB-1:0];
        idx_nxt = '0;
      end else if (rd_fire) begin
        idx_nxt = idx_r + CW'(1);
      end
      if (act.set_wa) begin
        wa_nxt = idx_m1[AW-1:0];
      end else if (act.wr_shift && rd_ok_r) begin
        wa_nxt = wa_r + AW'(1);
      end
      if (act.cnt_inc) begin
        count_nxt = count_r + CW'(1);
      end else if (act.cnt_dec) begin
        count_nxt = count_r - CW'(1);
      end
      if (act.emit) begin
        out_valid_nxt = 1'b1;
        out_user_nxt  = act.st;
        out_data_nxt  = act.key_sel ? 16'(rdata_r) : '0;
        out_last_nxt  = act.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= ckd_pkg::S_FETCH;
      count_r     <= '0;
      idx_r       <= '0;
      wa_r        <= '0;
      rd_ok_r     <= 1'b0;
      cap_r       <= 7'd64;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      wa_r        <= wa_nxt;
      rd_ok_r     <= rd_ok_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r      <= key_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  // key store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_fire) begin
      rdata_r <= mem[idx_r[AW-1:0]];
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_shift_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_fire && !act.wr_key) |-> (CW'(wa_r) < count_r))
    else $error("shift write at or above entry count");

  a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == ckd_pkg::S_SHIFT) |-> (count_r != '0))
    else $error("shift with empty directory");

  a_single_beat_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_user_r != ckd_pkg::STS_LISTED)) |-> out_last_r)
    else $error("single-beat result without last");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (go && act.wr_key) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("add did not grow the count");

endmodule
